[rtl/rbd_pkg.sv]
// Shared constants, register codes and types of the RGB bilinear downscaler.
`timescale 1ns / 1ps
package rbd_pkg;

    localparam int DEF_MAX_IN_WIDTH = 1024;
    localparam int DEF_CHANNELS     = 3;
    localparam int IO_CHANNELS      = 3;

    localparam int PIX_W      = 8;
    localparam int COORD_W    = 10;
    localparam int DIM_W      = 11;
    localparam int POS_W      = 27;
    localparam int FRAC_LSB   = 8;
    localparam int INT_LSB    = 16;
    localparam int ACC_W      = 16;
    localparam int SUM_W      = 25;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 27;
    localparam int S_DATA_W   = 24;
    localparam int M_DATA_W   = 48;

    // Weight of 1.0 in the 8-bit fraction
    localparam logic [PIX_W:0] WGT_ONE = 9'd256;

    typedef logic [PIX_W-1:0] pix_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IN_WIDTH   = 3'd0,
        REG_IN_HEIGHT  = 3'd1,
        REG_OUT_WIDTH  = 3'd2,
        REG_OUT_HEIGHT = 3'd3,
        REG_STEP_X     = 3'd4,
        REG_STEP_Y     = 3'd5
    } cfg_reg_t;

    // Interpolation weights and edge flags shared by all lanes
    typedef struct packed {
        logic [PIX_W-1:0] fx;
        logic [PIX_W-1:0] fy;
        logic             hasx;
        logic             hasy;
    } rbd_wgt_t;

endpackage

[rtl/rbd_lane.sv]
// One color lane: neighbor selection and the two-step bilinear blend.
`timescale 1ns / 1ps
module rbd_lane (
    input  logic               clk,
    input  logic               ld,
    input  rbd_pkg::rbd_wgt_t  wgt,
    input  rbd_pkg::pix_t      cur,
    input  rbd_pkg::pix_t      left,
    input  rbd_pkg::pix_t      up,
    input  rbd_pkg::pix_t      ul,
    output rbd_pkg::pix_t      px
);
    import rbd_pkg::*;

    pix_t             p00;
    pix_t             p01;
    pix_t             p10;
    pix_t             p11;
    logic [PIX_W:0]   fxc;
    logic [PIX_W:0]   fyc;
    logic [ACC_W:0]   m00;
    logic [ACC_W:0]   m01;
    logic [ACC_W:0]   m10;
    logic [ACC_W:0]   m11;
    logic [ACC_W-1:0] top_next;
    logic [ACC_W-1:0] bot_next;
    logic [ACC_W-1:0] top_reg;
    logic [ACC_W-1:0] bot_reg;
    logic [PIX_W-1:0] fy_reg;
    logic [SUM_W-1:0] s_top;
    logic [SUM_W-1:0] s_bot;
    logic [SUM_W-1:0] s_sum;

    // Missing neighbors outside the image read as zero
    always_comb
    begin
        p11 = (wgt.hasx && wgt.hasy) ? cur : '0;
        p10 = wgt.hasy ? (wgt.hasx ? left : cur) : '0;
        p01 = wgt.hasx ? (wgt.hasy ? up : cur) : '0;
        p00 = wgt.hasx ? (wgt.hasy ? ul : left) : (wgt.hasy ? up : cur);
    end

    assign fxc      = WGT_ONE - {1'b0, wgt.fx};
    assign m00      = (ACC_W+1)'(p00) * (ACC_W+1)'(fxc);
    assign m01      = (ACC_W+1)'(p01) * (ACC_W+1)'(wgt.fx);
    assign m10      = (ACC_W+1)'(p10) * (ACC_W+1)'(fxc);
    assign m11      = (ACC_W+1)'(p11) * (ACC_W+1)'(wgt.fx);
    assign top_next = ACC_W'(m00 + m01);
    assign bot_next = ACC_W'(m10 + m11);

    always_ff @(posedge clk)
    begin
        if (ld)
        begin
            top_reg <= top_next;
            bot_reg <= bot_next;
            fy_reg  <= wgt.fy;
        end
    end

    assign fyc   = WGT_ONE - {1'b0, fy_reg};
    assign s_top = SUM_W'(top_reg) * SUM_W'(fyc);
    assign s_bot = SUM_W'(bot_reg) * SUM_W'(fy_reg);
    assign s_sum = s_top + s_bot;
    assign px    = s_sum[INT_LSB +: PIX_W];

endmodule

[rtl/rbd_merge.sv]
// Output stage: gathers the lane results and position into one held transaction.
`timescale 1ns / 1ps
module rbd_merge (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         ld,
    input  logic [rbd_pkg::IO_CHANNELS*rbd_pkg::PIX_W-1:0] rgb,
    input  logic [rbd_pkg::COORD_W-1:0]                  col,
    input  logic [rbd_pkg::COORD_W-1:0]                  row,
    input  logic                                         done,
    output logic                                         free,
    output logic                                         m_tvalid,
    input  logic                                         m_tready,
    output logic [rbd_pkg::M_DATA_W-1:0]                 m_tdata,  // out_red, out_green, out_blue, out_col, out_row
    output logic                                         m_tlast   // frame_done
);
    import rbd_pkg::*;

    localparam int PAD_W = M_DATA_W - IO_CHANNELS*PIX_W - 2*COORD_W;

    logic                valid_reg;
    logic [M_DATA_W-1:0] data_reg;
    logic                last_reg;

    assign free = !valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ld)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld)
        begin
            data_reg <= {{PAD_W{1'b0}}, row, col, rgb};
            last_reg <= done;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

endmodule

[rtl/rgb_bilinear_downscaler_core.sv]
// Top level of the RGB bilinear downscaler: sequencer, row store and color lanes.
`timescale 1ns / 1ps
// Usage:
//   Source pixels enter on the s_ channel in raster order, one transaction per pixel,
//   with s_tuser[0] high on pixel (0,0) of a frame. Each pixel produces at most one
//   output sample on the m_ channel; m_tlast marks the last sample of a frame.
//   Sizes and 11.16 steps are written through cfg_we/cfg_index/cfg_data while idle.
// Steps:
//   A pixel is taken in the idle state, then passes the registered row store read, then
//   neighbor selection with the horizontal blends; a pixel that completes a sample then
//   takes the vertical blend, which loads the registered output stage that drives
//   m_tvalid.
// Reset:
//   Registers return to 320x240 in, 64x64 out, steps 5.0 and 3.75; all positions clear.
//   The row store is not cleared; entries read in the first row of a frame feed no sample.
// Stall:
//   A finished sample waits in the output register while the next pixel is taken;
//   if that pixel completes a sample, it holds in the vertical blend step until the register frees.
module rgb_bilinear_downscaler_core #(
    parameter int MAX_IN_WIDTH = rbd_pkg::DEF_MAX_IN_WIDTH,
    parameter int CHANNELS     = rbd_pkg::DEF_CHANNELS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [rbd_pkg::S_DATA_W-1:0]      s_tdata,   // red, green, blue
    input  logic [0:0]                        s_tuser,   // frame_start
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [rbd_pkg::M_DATA_W-1:0]      m_tdata,   // out_red, out_green, out_blue, out_col, out_row
    output logic                              m_tlast,   // frame_done
    input  logic                              cfg_we,
    input  logic [rbd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rbd_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import rbd_pkg::*;

    localparam int SLOT_W = $clog2(MAX_IN_WIDTH);
    localparam int MEM_W  = CHANNELS * PIX_W;
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(MAX_IN_WIDTH - 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_CALC = 4'b0100,
        S_MUL  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [DIM_W-1:0] in_width_reg;
    logic [DIM_W-1:0] in_height_reg;
    logic [DIM_W-1:0] out_width_reg;
    logic [DIM_W-1:0] out_height_reg;
    logic [POS_W-1:0] step_x_reg;
    logic [POS_W-1:0] step_y_reg;

    logic [MEM_W-1:0] row_mem [MAX_IN_WIDTH];
    logic [MEM_W-1:0] cur_in;
    logic [MEM_W-1:0] cur_reg;
    logic [MEM_W-1:0] up_reg;
    logic [MEM_W-1:0] left_reg;
    logic [MEM_W-1:0] ul_reg;
    logic [MEM_W-1:0] lane_px;
    logic [IO_CHANNELS*PIX_W-1:0] rgb;

    logic [COORD_W-1:0] src_col_reg;
    logic [COORD_W-1:0] src_col_next;
    logic [COORD_W-1:0] src_row_reg;
    logic [COORD_W-1:0] src_row_next;
    logic [SLOT_W-1:0]  slot_reg;
    logic [SLOT_W-1:0]  slot_next;
    logic [POS_W-1:0]   sx_reg;
    logic [POS_W-1:0]   sx_next;
    logic [POS_W-1:0]   sy_reg;
    logic [POS_W-1:0]   sy_next;
    logic [COORD_W-1:0] ocol_reg;
    logic [COORD_W-1:0] ocol_next;
    logic [COORD_W-1:0] orow_reg;
    logic [COORD_W-1:0] orow_next;
    logic [COORD_W-1:0] pcol_reg;
    logic [COORD_W-1:0] prow_reg;
    logic               pdone_reg;

    logic             accept;
    logic             restart;
    logic [DIM_W-1:0] ix;
    logic [DIM_W-1:0] iy;
    logic [DIM_W:0]   ix1;
    logic [DIM_W:0]   iy1;
    logic [DIM_W:0]   tcol;
    logic [DIM_W:0]   trow;
    logic             hit;
    logic             calc_hit;
    logic             row_end;
    logic             frame_end;
    logic             src_row_end;
    logic             src_frame_end;
    logic [COORD_W-1:0] ocol_inc;
    logic [COORD_W-1:0] orow_inc;
    logic [COORD_W-1:0] scol_inc;
    logic [COORD_W-1:0] srow_inc;
    logic             out_free;
    logic             out_ld;
    rbd_wgt_t         wgt;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign restart  = accept && s_tuser[0];

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_width_reg   <= DIM_W'(320);
            in_height_reg  <= DIM_W'(240);
            out_width_reg  <= DIM_W'(64);
            out_height_reg <= DIM_W'(64);
            step_x_reg     <= POS_W'(327680);
            step_y_reg     <= POS_W'(245760);
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_IN_WIDTH:   in_width_reg   <= cfg_data[DIM_W-1:0];
                REG_IN_HEIGHT:  in_height_reg  <= cfg_data[DIM_W-1:0];
                REG_OUT_WIDTH:  out_width_reg  <= cfg_data[DIM_W-1:0];
                REG_OUT_HEIGHT: out_height_reg <= cfg_data[DIM_W-1:0];
                REG_STEP_X:     step_x_reg     <= cfg_data[POS_W-1:0];
                REG_STEP_Y:     step_y_reg     <= cfg_data[POS_W-1:0];
                default:        ;
            endcase
        end
    end

    // Spread the input fields over the lanes; extra lanes see zero
    for (genvar c = 0; c < CHANNELS; c++)
    begin : g_cur
        if (c < IO_CHANNELS)
        begin : g_io
            assign cur_in[c*PIX_W +: PIX_W] = s_tdata[c*PIX_W +: PIX_W];
        end
        else
        begin : g_pad
            assign cur_in[c*PIX_W +: PIX_W] = '0;
        end
    end

    // Sample geometry
    assign ix   = sx_reg[INT_LSB +: DIM_W];
    assign iy   = sy_reg[INT_LSB +: DIM_W];
    assign ix1  = {1'b0, ix} + (DIM_W+1)'(1);
    assign iy1  = {1'b0, iy} + (DIM_W+1)'(1);
    assign wgt.hasx = ix1 < {1'b0, in_width_reg};
    assign wgt.hasy = iy1 < {1'b0, in_height_reg};
    assign wgt.fx   = sx_reg[FRAC_LSB +: PIX_W];
    assign wgt.fy   = sy_reg[FRAC_LSB +: PIX_W];
    assign tcol = wgt.hasx ? ix1 : {1'b0, ix};
    assign trow = wgt.hasy ? iy1 : {1'b0, iy};
    assign hit  = ((DIM_W+1)'(src_col_reg) == tcol) && ((DIM_W+1)'(src_row_reg) == trow);
    assign calc_hit = (state_reg == S_CALC) && hit;

    assign ocol_inc  = ocol_reg + COORD_W'(1);
    assign orow_inc  = orow_reg + COORD_W'(1);
    assign row_end   = (ocol_inc == '0) || ({1'b0, ocol_inc} >= out_width_reg);
    assign frame_end = row_end && ((orow_inc == '0) || ({1'b0, orow_inc} >= out_height_reg));

    assign scol_inc      = src_col_reg + COORD_W'(1);
    assign srow_inc      = src_row_reg + COORD_W'(1);
    assign src_row_end   = (scol_inc == '0) || ({1'b0, scol_inc} >= in_width_reg);
    assign src_frame_end = (srow_inc == '0) || ({1'b0, srow_inc} >= in_height_reg);

    always_comb
    begin
        src_col_next = src_col_reg;
        src_row_next = src_row_reg;
        slot_next    = slot_reg;
        sx_next      = sx_reg;
        sy_next      = sy_reg;
        ocol_next    = ocol_reg;
        orow_next    = orow_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (restart)
                begin
                    src_col_next = '0;
                    src_row_next = '0;
                    slot_next    = '0;
                    sx_next      = '0;
                    sy_next      = '0;
                    ocol_next    = '0;
                    orow_next    = '0;
                end
            end
            S_CALC:
            begin
                if (src_row_end)
                begin
                    src_col_next = '0;
                    slot_next    = '0;
                    src_row_next = src_frame_end ? '0 : srow_inc;
                end
                else
                begin
                    src_col_next = scol_inc;
                    slot_next    = (slot_reg == SLOT_LAST) ? '0 : slot_reg + SLOT_W'(1);
                end
                if (hit)
                begin
                    if (!row_end)
                    begin
                        ocol_next = ocol_inc;
                        sx_next   = sx_reg + step_x_reg;
                    end
                    else
                    begin
                        ocol_next = '0;
                        sx_next   = '0;
                        if (frame_end)
                        begin
                            orow_next = '0;
                            sy_next   = '0;
                        end
                        else
                        begin
                            orow_next = orow_inc;
                            sy_next   = sy_reg + step_y_reg;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (accept) state_next = S_READ;
            S_READ:  state_next = S_CALC;
            S_CALC:  state_next = hit ? S_MUL : S_IDLE;
            S_MUL:   if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign out_ld = (state_reg == S_MUL) && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            src_col_reg <= '0;
            src_row_reg <= '0;
            slot_reg    <= '0;
            sx_reg      <= '0;
            sy_reg      <= '0;
            ocol_reg    <= '0;
            orow_reg    <= '0;
            left_reg    <= '0;
            ul_reg      <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            src_col_reg <= src_col_next;
            src_row_reg <= src_row_next;
            slot_reg    <= slot_next;
            sx_reg      <= sx_next;
            sy_reg      <= sy_next;
            ocol_reg    <= ocol_next;
            orow_reg    <= orow_next;
            if (state_reg == S_CALC)
            begin
                left_reg <= cur_reg;
                ul_reg   <= up_reg;
            end
        end
    end

    // Pixel capture, row store and pending sample position
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cur_reg <= cur_in;
        end
        if (state_reg == S_READ)
        begin
            up_reg <= row_mem[slot_reg];
        end
        if (state_reg == S_CALC)
        begin
            row_mem[slot_reg] <= cur_reg;
        end
        if (calc_hit)
        begin
            pcol_reg  <= ocol_reg;
            prow_reg  <= orow_reg;
            pdone_reg <= frame_end;
        end
    end

    for (genvar c = 0; c < CHANNELS; c++)
    begin : g_lane
        rbd_lane u_lane (
            .clk  (clk),
            .ld   (calc_hit),
            .wgt  (wgt),
            .cur  (cur_reg[c*PIX_W +: PIX_W]),
            .left (left_reg[c*PIX_W +: PIX_W]),
            .up   (up_reg[c*PIX_W +: PIX_W]),
            .ul   (ul_reg[c*PIX_W +: PIX_W]),
            .px   (lane_px[c*PIX_W +: PIX_W])
        );
    end

    for (genvar c = 0; c < IO_CHANNELS; c++)
    begin : g_rgb
        if (c < CHANNELS)
        begin : g_lane_out
            assign rgb[c*PIX_W +: PIX_W] = lane_px[c*PIX_W +: PIX_W];
        end
        else
        begin : g_zero
            assign rgb[c*PIX_W +: PIX_W] = '0;
        end
    end

    rbd_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .ld       (out_ld),
        .rgb      (rgb),
        .col      (pcol_reg),
        .row      (prow_reg),
        .done     (pdone_reg),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    a_mul_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL && !out_free) |=> (state_reg == S_MUL))
        else $error("blend step left while output register was full");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        (slot_reg <= SLOT_LAST))
        else $error("row store slot out of range");

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        restart |=> (src_col_reg == '0 && src_row_reg == '0 && sx_reg == '0
                     && ocol_reg == '0 && orow_reg == '0))
        else $error("frame start did not clear positions");

    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (calc_hit && frame_end) |=> (ocol_reg == '0 && orow_reg == '0 && sy_reg == '0
                                     && pdone_reg))
        else $error("output position not cleared after last sample");

endmodule

[test/rbd_sample_checker.sv]
// Scoreboard for the RGB bilinear downscaler: predicts output samples from pixel transactions.
`timescale 1ns / 1ps
module rbd_sample_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [rbd_pkg::S_DATA_W-1:0]      s_tdata,   // red, green, blue
    input  logic [0:0]                        s_tuser,   // frame_start
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [rbd_pkg::M_DATA_W-1:0]      m_tdata,   // out_red, out_green, out_blue, out_col, out_row
    input  logic                              m_tlast,   // frame_done
    input  logic                              cfg_we,
    input  logic [rbd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rbd_pkg::CFG_DATA_W-1:0]    cfg_data,
    output int                                errors,
    output int                                pending,
    output int                                pixels_seen,
    output int                                samples_seen,
    output int                                frames_seen
);
    import rbd_pkg::*;

    localparam int COL_LSB = IO_CHANNELS * PIX_W;
    localparam int ROW_LSB = COL_LSB + COORD_W;

    typedef struct packed {
        pix_t [IO_CHANNELS-1:0] rgb;
        logic [COORD_W-1:0]     col;
        logic [COORD_W-1:0]     row;
        logic                   last;
    } sample_t;

    sample_t expected_samples[$];

    logic [DIM_W-1:0]    in_w, in_h, out_w, out_h;
    logic [POS_W-1:0]    step_x, step_y, pos_x, pos_y;
    logic [S_DATA_W-1:0] row_above [DEF_MAX_IN_WIDTH];
    logic [S_DATA_W-1:0] left_px, upleft_px;
    logic [COORD_W-1:0]  src_col, src_row, dst_col, dst_row;

    task automatic rewind_positions();
        src_col = '0;
        src_row = '0;
        pos_x   = '0;
        pos_y   = '0;
        dst_col = '0;
        dst_row = '0;
    endtask

    function automatic pix_t blend_channel(input pix_t p00, p01, p10, p11,
                                           input logic [31:0] fx, fy);
        logic [31:0] upper, lower, total;
        upper = p00 * (32'd256 - fx) + p01 * fx;
        lower = p10 * (32'd256 - fx) + p11 * fx;
        total = (upper * (32'd256 - fy) + lower * fy) >> INT_LSB;
        return total[PIX_W-1:0];
    endfunction

    task automatic predict_pixel(input logic [S_DATA_W-1:0] cur, input logic frame_start);
        logic [S_DATA_W-1:0] above;
        logic [31:0]         ix, iy, fx, fy, tcol, trow;
        logic                hasx, hasy, row_end, frame_end;
        logic [COORD_W-1:0]  ncol, nrow;
        pix_t                p00, p01, p10, p11;
        sample_t             s;
        if (frame_start)
            rewind_positions();
        above = row_above[src_col % DEF_MAX_IN_WIDTH];
        ix    = pos_x >> INT_LSB;
        iy    = pos_y >> INT_LSB;
        fx    = (pos_x >> FRAC_LSB) & 32'hFF;
        fy    = (pos_y >> FRAC_LSB) & 32'hFF;
        hasx  = (ix + 32'd1) < in_w;
        hasy  = (iy + 32'd1) < in_h;
        tcol  = hasx ? ix + 32'd1 : ix;
        trow  = hasy ? iy + 32'd1 : iy;

        // The sample completes on its last in-image neighbor; missing neighbors weigh zero
        if (src_col == tcol && src_row == trow) begin
            for (int c = 0; c < IO_CHANNELS; c++) begin
                p11 = (hasx && hasy) ? cur[c*PIX_W +: PIX_W] : '0;
                p10 = hasy ? (hasx ? left_px[c*PIX_W +: PIX_W] : cur[c*PIX_W +: PIX_W]) : '0;
                p01 = hasx ? (hasy ? above[c*PIX_W +: PIX_W] : cur[c*PIX_W +: PIX_W]) : '0;
                p00 = hasx ? (hasy ? upleft_px[c*PIX_W +: PIX_W] : left_px[c*PIX_W +: PIX_W])
                           : (hasy ? above[c*PIX_W +: PIX_W] : cur[c*PIX_W +: PIX_W]);
                s.rgb[c] = blend_channel(p00, p01, p10, p11, fx, fy);
            end
            ncol      = dst_col + 1'b1;
            nrow      = dst_row + 1'b1;
            row_end   = (ncol == 0) || (ncol >= out_w);
            frame_end = row_end && ((nrow == 0) || (nrow >= out_h));
            s.col     = dst_col;
            s.row     = dst_row;
            s.last    = frame_end;
            expected_samples.push_back(s);
            if (!row_end) begin
                dst_col = ncol;
                pos_x   = pos_x + step_x;
            end else begin
                dst_col = '0;
                pos_x   = '0;
                if (frame_end) begin
                    dst_row = '0;
                    pos_y   = '0;
                end else begin
                    dst_row = nrow;
                    pos_y   = pos_y + step_y;
                end
            end
        end

        row_above[src_col % DEF_MAX_IN_WIDTH] = cur;
        upleft_px = above;
        left_px   = cur;

        // Advance the raster position; the column counter wraps at its own width too
        ncol = src_col + 1'b1;
        if (ncol == 0 || ncol >= in_w) begin
            src_col = '0;
            nrow    = src_row + 1'b1;
            src_row = (nrow == 0 || nrow >= in_h) ? '0 : nrow;
        end else begin
            src_col = ncol;
        end
    endtask

    task automatic report(input string msg);
        errors++;
        if (errors <= 10)
            $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    task automatic check_field(input string fname, input int got, input int want);
        if (got != want)
            report($sformatf("sample %0d %s: expected %0d, got %0d",
                             samples_seen, fname, want, got));
    endtask

    task automatic compare_sample();
        sample_t want;
        if (expected_samples.size() == 0) begin
            report($sformatf("unexpected sample at col %0d row %0d",
                             m_tdata[COL_LSB +: COORD_W], m_tdata[ROW_LSB +: COORD_W]));
            return;
        end
        want = expected_samples.pop_front();
        check_field("out_red",    m_tdata[0*PIX_W +: PIX_W], want.rgb[0]);
        check_field("out_green",  m_tdata[1*PIX_W +: PIX_W], want.rgb[1]);
        check_field("out_blue",   m_tdata[2*PIX_W +: PIX_W], want.rgb[2]);
        check_field("out_col",    m_tdata[COL_LSB +: COORD_W], want.col);
        check_field("out_row",    m_tdata[ROW_LSB +: COORD_W], want.row);
        check_field("frame_done", m_tlast, want.last);
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_w   = 11'd320;
            in_h   = 11'd240;
            out_w  = 11'd64;
            out_h  = 11'd64;
            step_x = 27'd327680;
            step_y = 27'd245760;
            foreach (row_above[i])
                row_above[i] = '0;
            left_px   = '0;
            upleft_px = '0;
            rewind_positions();
            expected_samples.delete();
            errors       = 0;
            pending      = 0;
            pixels_seen  = 0;
            samples_seen = 0;
            frames_seen  = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_reg_t'(cfg_index))
                    REG_IN_WIDTH:   in_w   = cfg_data[DIM_W-1:0];
                    REG_IN_HEIGHT:  in_h   = cfg_data[DIM_W-1:0];
                    REG_OUT_WIDTH:  out_w  = cfg_data[DIM_W-1:0];
                    REG_OUT_HEIGHT: out_h  = cfg_data[DIM_W-1:0];
                    REG_STEP_X:     step_x = cfg_data[POS_W-1:0];
                    REG_STEP_Y:     step_y = cfg_data[POS_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                pixels_seen++;
                predict_pixel(s_tdata, s_tuser[0]);
            end
            if (m_tvalid && m_tready) begin
                compare_sample();
                samples_seen++;
                if (m_tlast)
                    frames_seen++;
            end
            pending = expected_samples.size();
        end
    end

endmodule

[test/tb.sv]
// Testbench top for the RGB bilinear downscaler: stimulus, register setup and verdict.
`timescale 1ns / 1ps
module tb;
    import rbd_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int SMALL_ITEMS = 600;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;   // red, green, blue
    logic [0:0]            s_tuser;   // frame_start
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;   // out_red, out_green, out_blue, out_col, out_row
    logic                  m_tlast;   // frame_done
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int errors, pending, pixels_seen, samples_seen, frames_seen;
    int send_idle, recv_idle, stall_cycles, phases, small_items;

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    rgb_bilinear_downscaler_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    rbd_sample_checker sample_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .errors       (errors),
        .pending      (pending),
        .pixels_seen  (pixels_seen),
        .samples_seen (samples_seen),
        .frames_seen  (frames_seen)
    );

    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_idle);
    end

    // End the run when neither channel moves a transaction for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == STALL_LIMIT)
        begin
            $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic [S_DATA_W-1:0] random_rgb();
        logic [S_DATA_W-1:0] v;
        v = S_DATA_W'($urandom);
        for (int c = 0; c < IO_CHANNELS; c++)
            if ($urandom_range(7) == 0)
                v[c*PIX_W +: PIX_W] = $urandom_range(1) ? 8'hFF : 8'h00;
        return v;
    endfunction

    // Step that keeps every sample inside the source, or now and then any step from 1.0 to 1024.0
    function automatic logic [CFG_DATA_W-1:0] pick_step(input int span, input int count);
        int unsigned top;
        if (count < 2 || $urandom_range(7) == 0)
            return CFG_DATA_W'($urandom_range(32'd1 << 26, 32'd1 << 16));
        top = ((span - 1) << 16) / (count - 1);
        return CFG_DATA_W'($urandom_range(top, 32'd1 << 16));
    endfunction

    // Entered and left at a falling edge
    task automatic send_pixel(input logic [S_DATA_W-1:0] rgb, input logic fs);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= rgb;
        s_tuser  <= fs;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_frame(input int npix, input bit with_start, input bit noisy);
        for (int i = 0; i < npix; i++)
            send_pixel(random_rgb(),
                       (i == 0 && with_start) || (noisy && $urandom_range(199) == 0));
    endtask

    // Hold input until every sample is out, then let the pipeline empty
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t r, input logic [CFG_DATA_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= r;
        cfg_data  <= v;
        @(negedge clk);
    endtask

    task automatic set_geometry(input int iw, ih, ow, oh,
                                input logic [CFG_DATA_W-1:0] sx, sy);
        drain();
        write_reg(REG_IN_WIDTH, CFG_DATA_W'(iw));
        write_reg(REG_IN_HEIGHT, CFG_DATA_W'(ih));
        write_reg(REG_OUT_WIDTH, CFG_DATA_W'(ow));
        write_reg(REG_OUT_HEIGHT, CFG_DATA_W'(oh));
        write_reg(REG_STEP_X, sx);
        write_reg(REG_STEP_Y, sy);
        cfg_we <= 1'b0;
        phases++;
    endtask

    initial
    begin
        int iw, ih, ow, oh, nfr, npix;
        bit big_done;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        m_tready     = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = REG_IN_WIDTH;
        cfg_data     = '0;
        send_idle    = 10;
        recv_idle    = 46;
        stall_cycles = 0;
        phases       = 0;
        small_items  = 0;
        big_done     = 1'b0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // One-pixel image: every pixel comes straight back as a finished frame
        set_geometry(1, 1, 1, 1, 27'd65536, 27'd65536);
        send_pixel(24'h000000, 1'b1);
        send_pixel(24'hFFFFFF, 1'b0);
        send_pixel(24'hFF00FF, 1'b1);
        send_pixel(24'h00FF00, 1'b0);
        send_pixel(24'h5AA55A, 1'b0);
        send_pixel(24'hA55AA5, 1'b1);

        // 3x3 to 2x2: half weight across, nearly full weight down, edge samples
        set_geometry(3, 3, 2, 2, 27'd98304, 27'd130816);
        for (int i = 0; i < 9; i++)
            send_pixel({$urandom_range(1) ? 8'hFF : 8'h00, $urandom_range(1) ? 8'hFF : 8'h00,
                        $urandom_range(1) ? 8'hFF : 8'h00}, i == 0);

        // Steps of 1024.0: the second sample falls outside, so wait for the next frame start
        set_geometry(2, 2, 2, 2, 27'd67108864, 27'd67108864);
        send_frame(4, 1'b1, 1'b0);
        send_frame(4, 1'b0, 1'b0);
        send_frame(4, 1'b1, 1'b0);

        while (small_items < SMALL_ITEMS)
        begin
            iw = $urandom_range(12, 1);
            ih = $urandom_range(8, 1);
            ow = $urandom_range(iw, 1);
            oh = $urandom_range(ih, 1);
            set_geometry(iw, ih, ow, oh, pick_step(iw, ow), pick_step(ih, oh));
            nfr = $urandom_range(3, 1);
            for (int f = 0; f < nfr; f++)
            begin
                if (small_items < SMALL_ITEMS / 3)
                begin
                    send_idle = 10;
                    recv_idle = 46;
                end
                else if (small_items < 2 * SMALL_ITEMS / 3)
                begin
                    send_idle = 46;
                    recv_idle = 10;
                end
                else
                begin
                    send_idle = 0;
                    recv_idle = 0;
                end
                npix = iw * ih;
                // Cut some frames short; the next one may or may not carry a frame start
                if ($urandom_range(5) == 0)
                    npix = $urandom_range(npix, 1);
                send_frame(npix, f == 0 || $urandom_range(3) != 0, 1'b1);
                small_items += npix;
                if ($urandom_range(9) == 0)
                    drain();
            end
            if (!big_done && small_items >= SMALL_ITEMS / 2)
            begin
                // Widest row, cut short after a few dozen pixels
                set_geometry(1024, 1, 1024, 1, 27'd65536, 27'd65536);
                send_frame(64, 1'b1, 1'b0);
                // Tallest source, cut short after 48 rows
                set_geometry(1, 1024, 1, 1024, 27'd65536, 27'd65536);
                send_frame(48, 1'b1, 1'b0);
                big_done = 1'b1;
            end
        end

        drain();
        $display("Checked %0d samples (%0d frames closed) from %0d pixels over %0d geometries",
                 samples_seen, frames_seen, pixels_seen, phases);
        $display("Covered 1x1 and 1024-wide/tall sources, extreme steps, cut and chained frames");
        if (errors == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[sim.f]
rtl/rbd_pkg.sv
rtl/rbd_lane.sv
rtl/rbd_merge.sv
rtl/rgb_bilinear_downscaler_core.sv
test/rbd_sample_checker.sv
test/tb.sv
